// ===== hdl/frwl_pkg.sv =====
// Shared types and constants of the first-come readers-writer lock arbiter.
// Used by frwl_ctrl, frwl_datapath and fair_readers_writer_lock_arbiter.
// No dependencies.
package frwl_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_WIDTH_DEF    = 8;

    // Grants emitted for one event at most
    localparam int MAX_RESULTS = 16;
    localparam int GRANT_CNT_W = $clog2(MAX_RESULTS + 1);

    localparam int                 READERS_W   = 9;
    localparam logic [READERS_W-1:0] READERS_MAX = 9'd511;

    typedef enum logic [1:0] {
        KIND_READ_REQ  = 2'd0,
        KIND_WRITE_REQ = 2'd1,
        KIND_READ_REL  = 2'd2,
        KIND_WRITE_REL = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_QUEUE_FULL = 2'd1,
        ERR_NO_HOLD    = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_SEND
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic event_en;          // apply the accepted event
        logic grant_en;          // grant the head entry into the pending slot
        logic out_load;          // load the output register
        logic out_from_pending;  // 1: pending grant, 0: non-grant result
        logic out_last;          // last flag of the loaded result
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic grantable;         // head entry may go now
        logic pending;           // a grant waits to be sent
        logic out_last;          // output register holds the final result
    } stat_t;

endpackage

// ===== hdl/fair_readers_writer_lock_arbiter.sv =====
// First-come readers-writer lock arbiter, top level.
// Instantiates frwl_ctrl and frwl_datapath; depends on frwl_pkg.
//
// Input channel (in_valid/in_ready): one lock event per transfer, kind
// 0 read request, 1 write request, 2 read release, 3 write release, with the
// requester id. Requests queue in arrival order (QUEUE_DEPTH entries); a
// request finding the queue full is dropped with error_code 1, a release with
// nothing held is ignored with error_code 2.
// Output channel (out_valid/out_ready): after each event the head of the queue
// is granted while it may go, one result per grant (at most 16 per event); a
// run of readers goes together. An event without grant gives one non-grant
// result carrying the error code. last marks the final result of an event.
// Sequencing: the queue memory has a registered read port, so each grant
// passes through a read state and a check state before its result is loaded
// into the output register. One event is handled at a time: in_ready is high
// only in the idle state, which is entered in the cycle after the final result
// of the previous event transfers. A stalled receiver holds the result in the
// output register and the arbiter waits. Reset clears queue pointers, reader
// count and writer flag.
module fair_readers_writer_lock_arbiter
#(
    parameter int QUEUE_DEPTH = frwl_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH    = frwl_pkg::ID_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          kind,
    input  logic [ID_WIDTH-1:0] requester_id,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                grant_valid,
    output logic [ID_WIDTH-1:0] granted_id,
    output logic                granted_is_write,
    output logic [1:0]          error_code,
    output logic                last
);

    frwl_pkg::cmd_t  cmd;
    frwl_pkg::stat_t stat;

    // controller: event accept, grant walk, output transfer
    frwl_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: queue memory, lock state, result register
    frwl_datapath
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    )
    u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .kind             (kind),
        .requester_id     (requester_id),
        .grant_valid      (grant_valid),
        .granted_id       (granted_id),
        .granted_is_write (granted_is_write),
        .error_code       (error_code),
        .last             (last)
    );

endmodule

// ===== hdl/frwl_ctrl.sv =====
// Sequencer of the readers-writer lock arbiter: accepts an event, walks the
// queue head one grant at a time and drives the output transfer.
// Depends on frwl_pkg.
module frwl_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  frwl_pkg::stat_t stat,
    output frwl_pkg::cmd_t  cmd
);

    frwl_pkg::state_t state_reg;
    frwl_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= frwl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            frwl_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.event_en = 1'b1;
                    state_next   = frwl_pkg::ST_READ;
                end
            end
            // head entry read settles
            frwl_pkg::ST_READ:
            begin
                state_next = frwl_pkg::ST_CHECK;
            end
            frwl_pkg::ST_CHECK:
            begin
                if (stat.grantable && !stat.pending)
                begin
                    cmd.grant_en = 1'b1;
                    state_next   = frwl_pkg::ST_READ;
                end
                else
                begin
                    // another grant follows only if the head may still go
                    cmd.out_load         = 1'b1;
                    cmd.out_from_pending = stat.pending;
                    cmd.out_last         = !stat.grantable;
                    state_next           = frwl_pkg::ST_SEND;
                end
            end
            frwl_pkg::ST_SEND:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = stat.out_last ? frwl_pkg::ST_IDLE : frwl_pkg::ST_CHECK;
                end
            end
            default:
            begin
                state_next = frwl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/frwl_datapath.sv =====
// Datapath of the readers-writer lock arbiter: request queue memory, lock
// state, pending grant and output register.
// Depends on frwl_pkg.
module frwl_datapath
#(
    parameter int QUEUE_DEPTH = frwl_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH    = frwl_pkg::ID_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  frwl_pkg::cmd_t      cmd,
    output frwl_pkg::stat_t     stat,
    input  logic [1:0]          kind,
    input  logic [ID_WIDTH-1:0] requester_id,
    output logic                grant_valid,
    output logic [ID_WIDTH-1:0] granted_id,
    output logic                granted_is_write,
    output logic [1:0]          error_code,
    output logic                last
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int RW    = frwl_pkg::READERS_W;
    localparam int GW    = frwl_pkg::GRANT_CNT_W;

    // entry: {is_reader, id}
    logic [ID_WIDTH:0]  mem [QUEUE_DEPTH];
    logic [ID_WIDTH:0]  rd_data_reg;

    logic [PTR_W-1:0]   head_reg, head_next, head_inc;
    logic [PTR_W-1:0]   tail_reg, tail_next, tail_inc;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [RW-1:0]      readers_reg, readers_next;
    logic               writer_reg, writer_next;
    logic [GW-1:0]      gcnt_reg, gcnt_next;
    logic               pending_reg, pending_next;
    frwl_pkg::err_t     err_reg, err_next;
    logic               wr_en;

    logic [ID_WIDTH-1:0] pending_id_reg;
    logic                pending_write_reg;

    logic                grant_valid_reg;
    logic [ID_WIDTH-1:0] granted_id_reg;
    logic                granted_is_write_reg;
    frwl_pkg::err_t      error_code_reg;
    logic                last_reg;

    frwl_pkg::kind_t     kind_e;
    logic                head_is_reader;
    logic                queue_full;

    assign kind_e         = frwl_pkg::kind_t'(kind);
    assign head_is_reader = rd_data_reg[ID_WIDTH];
    assign queue_full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_inc = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    // head may go: readers need no writer and a free count, writers need nothing held
    assign stat.grantable = (count_reg != '0)
                          && (gcnt_reg != GW'(frwl_pkg::MAX_RESULTS))
                          && !writer_reg
                          && (head_is_reader ? (readers_reg != frwl_pkg::READERS_MAX)
                                             : (readers_reg == '0));
    assign stat.pending  = pending_reg;
    assign stat.out_last = last_reg;

    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        readers_next = readers_reg;
        writer_next  = writer_reg;
        gcnt_next    = gcnt_reg;
        pending_next = pending_reg;
        err_next     = err_reg;
        wr_en        = 1'b0;

        if (cmd.event_en)
        begin
            gcnt_next = '0;
            err_next  = frwl_pkg::ERR_NONE;
            unique case (kind_e) inside
                frwl_pkg::KIND_READ_REQ, frwl_pkg::KIND_WRITE_REQ:
                begin
                    if (queue_full)
                    begin
                        err_next = frwl_pkg::ERR_QUEUE_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        tail_next  = tail_inc;
                        count_next = count_reg + 1'b1;
                    end
                end
                frwl_pkg::KIND_READ_REL:
                begin
                    if (readers_reg == '0)
                    begin
                        err_next = frwl_pkg::ERR_NO_HOLD;
                    end
                    else
                    begin
                        readers_next = readers_reg - 1'b1;
                    end
                end
                frwl_pkg::KIND_WRITE_REL:
                begin
                    if (!writer_reg)
                    begin
                        err_next = frwl_pkg::ERR_NO_HOLD;
                    end
                    else
                    begin
                        writer_next = 1'b0;
                    end
                end
                default:
                begin
                    err_next = frwl_pkg::ERR_NONE;
                end
            endcase
        end

        if (cmd.grant_en)
        begin
            if (head_is_reader)
            begin
                readers_next = readers_reg + 1'b1;
            end
            else
            begin
                writer_next = 1'b1;
            end
            head_next    = head_inc;
            count_next   = count_reg - 1'b1;
            gcnt_next    = gcnt_reg + 1'b1;
            pending_next = 1'b1;
        end

        if (cmd.out_load && cmd.out_from_pending)
        begin
            pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            readers_reg <= '0;
            writer_reg  <= 1'b0;
            gcnt_reg    <= '0;
            pending_reg <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            readers_reg <= readers_next;
            writer_reg  <= writer_next;
            gcnt_reg    <= gcnt_next;
            pending_reg <= pending_next;
        end
    end

    // queue memory: one write port, registered read of the head
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[tail_reg] <= {(kind_e == frwl_pkg::KIND_READ_REQ), requester_id};
        end
        rd_data_reg <= mem[head_reg];
    end

    always_ff @(posedge clk)
    begin
        err_reg <= err_next;
        if (cmd.grant_en)
        begin
            pending_id_reg    <= rd_data_reg[ID_WIDTH-1:0];
            pending_write_reg <= !head_is_reader;
        end
        if (cmd.out_load)
        begin
            last_reg <= cmd.out_last;
            if (cmd.out_from_pending)
            begin
                grant_valid_reg      <= 1'b1;
                granted_id_reg       <= pending_id_reg;
                granted_is_write_reg <= pending_write_reg;
                error_code_reg       <= frwl_pkg::ERR_NONE;
            end
            else
            begin
                grant_valid_reg      <= 1'b0;
                granted_id_reg       <= '0;
                granted_is_write_reg <= 1'b0;
                error_code_reg       <= err_reg;
            end
        end
    end

    assign grant_valid      = grant_valid_reg;
    assign granted_id       = granted_id_reg;
    assign granted_is_write = granted_is_write_reg;
    assign error_code       = error_code_reg;
    assign last             = last_reg;

    // a writer never holds the lock together with readers
    assert property (@(posedge clk) disable iff (!rst_n)
        !(writer_reg && (readers_reg != '0)))
        else $error("writer and readers hold the lock together");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        gcnt_reg <= GW'(frwl_pkg::MAX_RESULTS))
        else $error("more grants than allowed for one event");

    // a grant lands in an empty pending slot
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.grant_en |-> !pending_reg)
        else $error("pending grant overwritten");

endmodule

// ===== bench/fair_readers_writer_lock_arbiter_tb.sv =====
// Self-checking testbench for the first-come readers-writer lock arbiter.
// Depends on frwl_pkg and fair_readers_writer_lock_arbiter; predicts every
// result of every lock event and checks it against the output transfers.
`timescale 1ns / 1ps

module fair_readers_writer_lock_arbiter_tb;

    localparam int QDEPTH      = frwl_pkg::QUEUE_DEPTH_DEF;
    localparam int IDW         = frwl_pkg::ID_WIDTH_DEF;
    localparam int STALL_LIMIT = 5000;   // cycles without any transfer
    localparam int TAIL_CYCLES = 20;     // settle time after the last result
    localparam int RANDOM_ITEMS = 225;

    // One pending lock event, or a marker that makes the sender wait for a drain
    typedef struct {
        logic            drain;
        frwl_pkg::kind_t kind;
        logic [IDW-1:0]  id;
    } lock_event_t;

    // One result the arbiter owes
    typedef struct {
        logic           grant_valid;
        logic [IDW-1:0] granted_id;
        logic           granted_is_write;
        frwl_pkg::err_t error_code;
        logic           last;
    } lock_result_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_ready;
    logic [1:0]     kind = 2'd0;
    logic [IDW-1:0] requester_id = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    logic           grant_valid;
    logic [IDW-1:0] granted_id;
    logic           granted_is_write;
    logic [1:0]     error_code;
    logic           last;

    lock_event_t  event_queue[$];
    lock_result_t lock_results_due[$];
    int           mismatches = 0;

    // Shadow of the lock: waiting requests, reader count, writer flag
    logic [IDW-1:0]                 wait_ids[QDEPTH];
    logic                           wait_reader[QDEPTH];
    int unsigned                    wait_head = 0;
    int unsigned                    wait_tail = 0;
    int unsigned                    wait_count = 0;
    logic [frwl_pkg::READERS_W-1:0] readers_held = '0;
    logic                           writer_held = 1'b0;

    always #5 clk = ~clk;

    fair_readers_writer_lock_arbiter dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .kind             (kind),
        .requester_id     (requester_id),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .grant_valid      (grant_valid),
        .granted_id       (granted_id),
        .granted_is_write (granted_is_write),
        .error_code       (error_code),
        .last             (last)
    );

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s got %0d want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Apply one lock event to the shadow and queue the results it causes.
    // The last grant is held back one step so its last flag can be set.
    task automatic predict_lock_event(input frwl_pkg::kind_t ev_kind,
                                      input logic [IDW-1:0] ev_id);
        frwl_pkg::err_t err;
        int             n;
        logic           go;
        logic           have_prev;
        lock_result_t   prev;
        lock_result_t   r;
        err = frwl_pkg::ERR_NONE;
        n = 0;
        go = 1'b1;
        have_prev = 1'b0;
        case (ev_kind)
            frwl_pkg::KIND_READ_REQ, frwl_pkg::KIND_WRITE_REQ:
            begin
                if (wait_count >= QDEPTH)
                    err = frwl_pkg::ERR_QUEUE_FULL;
                else
                begin
                    wait_ids[wait_tail] = ev_id;
                    wait_reader[wait_tail] = (ev_kind == frwl_pkg::KIND_READ_REQ);
                    wait_tail = (wait_tail + 1) % QDEPTH;
                    wait_count++;
                end
            end
            frwl_pkg::KIND_READ_REL:
            begin
                if (readers_held == 0)
                    err = frwl_pkg::ERR_NO_HOLD;
                else
                    readers_held--;
            end
            default:
            begin
                if (!writer_held)
                    err = frwl_pkg::ERR_NO_HOLD;
                else
                    writer_held = 1'b0;
            end
        endcase
        // grant from the head while it may go
        while (go && wait_count > 0 && n < frwl_pkg::MAX_RESULTS)
        begin
            if (wait_reader[wait_head])
                go = !writer_held && (readers_held < frwl_pkg::READERS_MAX);
            else
                go = !writer_held && (readers_held == 0);
            if (go)
            begin
                if (wait_reader[wait_head])
                    readers_held++;
                else
                    writer_held = 1'b1;
                r.grant_valid = 1'b1;
                r.granted_id = wait_ids[wait_head];
                r.granted_is_write = !wait_reader[wait_head];
                r.error_code = frwl_pkg::ERR_NONE;
                r.last = 1'b0;
                if (have_prev)
                    lock_results_due.push_back(prev);
                prev = r;
                have_prev = 1'b1;
                n++;
                wait_head = (wait_head + 1) % QDEPTH;
                wait_count--;
            end
        end
        if (have_prev)
        begin
            prev.last = 1'b1;
            lock_results_due.push_back(prev);
        end
        else
        begin
            r.grant_valid = 1'b0;
            r.granted_id = '0;
            r.granted_is_write = 1'b0;
            r.error_code = err;
            r.last = 1'b1;
            lock_results_due.push_back(r);
        end
    endtask

    task automatic push_event(input frwl_pkg::kind_t k, input logic [IDW-1:0] id);
        lock_event_t e;
        e.drain = 1'b0;
        e.kind = k;
        e.id = id;
        event_queue.push_back(e);
    endtask

    // Sender pauses here until every owed result has been taken
    task automatic push_drain();
        lock_event_t e;
        e.drain = 1'b1;
        e.kind = frwl_pkg::KIND_READ_REQ;
        e.id = '0;
        event_queue.push_back(e);
    endtask

    // Driver: bursts of transfers separated by random gaps.
    // The shadow lock is updated at the edge where an event transfers.
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        logic        next_valid;
        logic        accepted;
        lock_event_t head;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            kind <= 2'd0;
            requester_id <= '0;
            wait_head = 0;
            wait_tail = 0;
            wait_count = 0;
            readers_held = '0;
            writer_held = 1'b0;
            burst_left = 1;
            gap_left = 0;
        end
        else
        begin
            accepted = in_valid && in_ready;
            next_valid = in_valid && !accepted;
            if (accepted)
                predict_lock_event(frwl_pkg::kind_t'(kind), requester_id);
            if (!next_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (event_queue.size() != 0)
                begin
                    head = event_queue[0];
                    if (head.drain)
                    begin
                        if (lock_results_due.size() == 0)
                            void'(event_queue.pop_front());
                    end
                    else
                    begin
                        void'(event_queue.pop_front());
                        next_valid = 1'b1;
                        kind <= head.kind;
                        requester_id <= head.id;
                        burst_left--;
                        if (burst_left <= 0)
                        begin
                            // long bursts give stretches with no idling at all
                            burst_left = $urandom_range(1, 40);
                            gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
                        end
                    end
                end
            end
            in_valid <= next_valid;
        end
    end

    // Monitor and receiver: a changing stall pattern, plus one long hold-off
    // while the sender keeps offering events, so the arbiter backs up.
    int   results_seen = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;
    int   rx_mode = 0;
    int   rx_mode_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        logic         rdy;
        lock_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left = 0;
            rx_mode_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (lock_results_due.size() == 0)
                    report_mismatch("result with none owed, granted_id", granted_id, 0);
                else
                begin
                    want = lock_results_due.pop_front();
                    if (grant_valid !== want.grant_valid)
                        report_mismatch("grant_valid", grant_valid, want.grant_valid);
                    if (granted_id !== want.granted_id)
                        report_mismatch("granted_id", granted_id, want.granted_id);
                    if (granted_is_write !== want.granted_is_write)
                        report_mismatch("granted_is_write", granted_is_write,
                                        want.granted_is_write);
                    if (error_code !== want.error_code)
                        report_mismatch("error_code", error_code, want.error_code);
                    if (last !== want.last)
                        report_mismatch("last", last, want.last);
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (!hold_done && results_seen >= 60)
            begin
                hold_done = 1'b1;
                hold_left = 400;
                rdy = 1'b0;
            end
            else
            begin
                if (rx_mode_left <= 0)
                begin
                    rx_mode = $urandom_range(0, 2);
                    rx_mode_left = $urandom_range(5, 60);
                end
                rx_mode_left--;
                case (rx_mode)
                    0:       rdy = 1'b1;
                    1:       rdy = $urandom_range(0, 1);
                    default: rdy = ($urandom_range(0, 3) == 0);
                endcase
            end
            out_ready <= rdy;
        end
    end

    // Watchdog: too long with no transfer on either side ends the run
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int n_rand;
        int sel;
        int k;
        int i;

        // Directed: releases with nothing held, then a writer holding the lock
        // while readers fill the queue, two requests beyond full, and a write
        // release that hands the lock to the whole run of readers at once.
        push_event(frwl_pkg::KIND_READ_REL, 8'd0);
        push_event(frwl_pkg::KIND_WRITE_REL, 8'd255);
        push_event(frwl_pkg::KIND_WRITE_REQ, 8'd0);
        push_event(frwl_pkg::KIND_READ_REQ, 8'd255);
        push_event(frwl_pkg::KIND_READ_REQ, 8'd0);
        for (i = 0; i < QDEPTH - 2; i++)
            push_event(frwl_pkg::KIND_READ_REQ, IDW'($urandom_range(0, 255)));
        push_event(frwl_pkg::KIND_WRITE_REQ, 8'hA5);
        push_event(frwl_pkg::KIND_READ_REQ, 8'h5A);
        push_event(frwl_pkg::KIND_WRITE_REL, 8'd1);
        push_drain();

        // Random: mostly well-formed writer/reader sessions, some request
        // bursts that overflow the queue, and some noise.
        n_rand = 0;
        while (n_rand < RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 9);
            if (sel <= 5)
            begin
                k = $urandom_range(0, 5);
                push_event(frwl_pkg::KIND_WRITE_REQ, IDW'($urandom_range(0, 255)));
                for (i = 0; i < k; i++)
                    push_event(frwl_pkg::KIND_READ_REQ, IDW'($urandom_range(0, 255)));
                push_event(frwl_pkg::KIND_WRITE_REL, IDW'($urandom_range(0, 255)));
                for (i = 0; i < k; i++)
                    push_event(frwl_pkg::KIND_READ_REL, IDW'($urandom_range(0, 255)));
                n_rand += 2 + 2 * k;
            end
            else if (sel <= 8)
            begin
                k = $urandom_range(4, 18);
                for (i = 0; i < k; i++)
                    push_event(frwl_pkg::kind_t'($urandom_range(0, 1)),
                               IDW'($urandom_range(0, 255)));
                for (i = 0; i < k; i++)
                    push_event(frwl_pkg::kind_t'($urandom_range(2, 3)),
                               IDW'($urandom_range(0, 255)));
                n_rand += 2 * k;
            end
            else
            begin
                push_event(frwl_pkg::kind_t'($urandom_range(0, 3)),
                           IDW'($urandom_range(0, 255)));
                n_rand++;
            end
            if ($urandom_range(0, 19) == 0)
                push_drain();
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (event_queue.size() != 0 || lock_results_due.size() != 0 || in_valid)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (lock_results_due.size() != 0)
            report_mismatch("results still owed", 0, lock_results_due.size());
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
